// ----- src/lsepg_pkg.sv -----
// ----------------------------------------------------------------------------
// lsepg_pkg
// Shared types and constants of the LED strip effect pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsepg_pkg;

    localparam int IDX_W    = 6;   // pixel index width
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 24;  // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CH   = 3;   // red, green, blue

    // serial step counts: index modulo, then channel division on c/2
    localparam int MOD_STEPS = IDX_W;
    localparam int DIV_STEPS = BYTE_W - 1;

    typedef logic [BYTE_W-1:0] t_byte;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_VALUE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APA102_TYPE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_LENGTH     = 3'd5;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_SOLID   = 2'd1,
        MODE_SCANNER = 2'd2,
        MODE_GLOW    = 2'd3
    } t_effect;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIV,
        ST_FIN
    } t_state;

    // reset values
    localparam logic [23:0] COLOUR_RESET     = 24'h001100;
    localparam logic [4:0]  BRIGHTNESS_RESET = 5'd1;
    localparam logic [6:0]  LED_COUNT_RESET  = 7'd64;
    localparam logic [3:0]  TRAIL_RESET      = 4'd2;
    localparam logic [3:0]  GLOW_RESET       = 4'd5;
    localparam logic [3:0]  GLOW_DEFAULT     = 4'd5;   // a width of zero counts as this
    localparam logic [2:0]  GLOBAL_MARK      = 3'b111; // top bits of the apa102 global byte

endpackage

`default_nettype wire

// ----- src/lsepg_in_if.sv -----
// ----------------------------------------------------------------------------
// lsepg_in_if
// Pixel request channel: pixel index and last-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsepg_in_if;
    import lsepg_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_index;
    logic             frame_last;

    modport source (output valid, pixel_index, frame_last, input ready);
    modport sink   (input valid, pixel_index, frame_last, output ready);
endinterface

`default_nettype wire

// ----- src/lsepg_out_if.sv -----
// ----------------------------------------------------------------------------
// lsepg_out_if
// Pixel result channel: global byte and the three colour bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsepg_out_if;
    import lsepg_pkg::*;

    logic  valid;
    logic  ready;
    t_byte global_byte;
    logic  global_valid;
    t_byte red_byte;
    t_byte green_byte;
    t_byte blue_byte;
    logic  frame_done;

    modport source (output valid, global_byte, global_valid, red_byte, green_byte,
                    blue_byte, frame_done, input ready);
    modport sink   (input valid, global_byte, global_valid, red_byte, green_byte,
                    blue_byte, frame_done, output ready);
endinterface

`default_nettype wire

// ----- src/led_strip_effect_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// led_strip_effect_pixel_generator
// Per-pixel colour generator for an LED strip: off, solid colour, bouncing
// scanner with fading trail, and soft glow.
// ----------------------------------------------------------------------------
// One pixel request goes in, one pixel result comes out. The request is taken
// only while the generator is idle; the result sits in an output register, so
// a new request can be taken while the previous result still waits for its
// transfer. Off, solid colour, pixels beyond the strip and the scanner head
// go straight to the finishing state; a scanner trail pixel runs 7 steps of a
// bit-serial divider (one quotient bit a cycle, per channel); soft glow first
// finds index modulo glow width with a 6-step bit-serial remainder unit and
// then runs the divider. A finished result waits in its last state if the
// output register is still occupied. The fade c - c/(2m) is worked as
// c - (c>>1)/m. Animation state (scanner head, direction, glow width) moves
// on when a request marked last of frame is taken.
`default_nettype none

module led_strip_effect_pixel_generator #(
    parameter int NUM_LEDS  = 64,
    parameter int MAX_TRAIL = 15
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [lsepg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [lsepg_pkg::CFG_W-1:0]       i_cfg_data,
    lsepg_in_if.sink                         i_pix,
    lsepg_out_if.source                      o_pix
);
    import lsepg_pkg::*;

    // strip length and trail length ceilings, settled at elaboration
    localparam logic [6:0] STRIP_MAX = 7'((NUM_LEDS < 64) ? NUM_LEDS : 64);
    localparam logic [3:0] TRAIL_CAP = 4'((MAX_TRAIL < 15) ? MAX_TRAIL : 15);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_effect     r_effect_mode;
    logic [23:0] r_colour_value;
    logic [4:0]  r_brightness_level;
    logic [6:0]  r_led_count;
    logic        r_apa102_type;
    logic [3:0]  r_trail_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode      <= MODE_SOLID;
            r_colour_value     <= COLOUR_RESET;
            r_brightness_level <= BRIGHTNESS_RESET;
            r_led_count        <= LED_COUNT_RESET;
            r_apa102_type      <= 1'b0;
            r_trail_length     <= TRAIL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EFFECT_MODE:      r_effect_mode      <= t_effect'(i_cfg_data[1:0]);
                CFG_COLOUR_VALUE:     r_colour_value     <= i_cfg_data[23:0];
                CFG_BRIGHTNESS_LEVEL: r_brightness_level <= i_cfg_data[4:0];
                CFG_LED_COUNT:        r_led_count        <= i_cfg_data[6:0];
                CFG_APA102_TYPE:      r_apa102_type      <= i_cfg_data[0];
                CFG_TRAIL_LENGTH:     r_trail_length     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control state and datapath registers
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [2:0]       r_cnt;
    logic [5:0]       r_head;      // scanner head position
    logic             r_dir;       // 1 moving up, 0 moving down
    logic [3:0]       r_glow;      // glow width
    logic             r_out_valid;

    logic [IDX_W-1:0] r_x;         // index, shifted out msb first for the modulo
    logic [3:0]       r_mod_rem;
    logic [3:0]       r_w;         // glow modulus
    logic [3:0]       r_div_m;     // divisor m of c/(2m)
    t_byte            r_chan [NUM_CH];
    logic [6:0]       r_dvd  [NUM_CH];  // dividend in, quotient out
    logic [3:0]       r_rem  [NUM_CH];
    logic             r_pass;      // result is the channel value as is
    logic             r_last;

    t_byte            r_global_byte;
    logic             r_global_valid;
    t_byte            r_out_ch [NUM_CH];
    logic             r_frame_done;

    // ------------------------------------------------------------------
    // request decode, narrow logic on the accepting cycle
    // ------------------------------------------------------------------
    logic       accept;
    logic [6:0] strip_n;
    logic       in_strip;
    logic [3:0] trail;
    logic [5:0] trail_dist;
    logic       trail_hit;
    logic [3:0] glow_w;
    t_byte      colour_ch [NUM_CH];
    logic       dec_pass, dec_zero, dec_glow;
    logic [3:0] dec_m;

    assign accept = i_pix.valid && i_pix.ready;

    always_comb begin
        colour_ch[0] = r_colour_value[7:0];
        colour_ch[1] = r_colour_value[15:8];
        colour_ch[2] = r_colour_value[23:16];

        if (r_led_count == 7'd0) begin
            strip_n = 7'd1;
        end else if (r_led_count > STRIP_MAX) begin
            strip_n = STRIP_MAX;
        end else begin
            strip_n = r_led_count;
        end
        in_strip = {1'b0, i_pix.pixel_index} < strip_n;

        trail = (r_trail_length > TRAIL_CAP) ? TRAIL_CAP : r_trail_length;
        if ({3'b000, trail} > strip_n) begin
            trail = 4'd0;
        end

        // distance behind the head, in the direction the head came from
        if (r_dir && (i_pix.pixel_index < r_head)) begin
            trail_dist = r_head - i_pix.pixel_index;
        end else if (!r_dir && (i_pix.pixel_index > r_head)) begin
            trail_dist = i_pix.pixel_index - r_head;
        end else begin
            trail_dist = 6'd0;
        end
        trail_hit = (trail != 4'd0) && (trail_dist != 6'd0)
                    && (trail_dist <= {2'b00, trail});

        glow_w = (r_glow == 4'd0) ? GLOW_DEFAULT : r_glow;

        dec_pass = 1'b0;
        dec_zero = 1'b1;
        dec_glow = 1'b0;
        dec_m    = 4'd1;
        if (in_strip) begin
            case (r_effect_mode)
                MODE_SOLID: begin
                    dec_pass = 1'b1;
                    dec_zero = 1'b0;
                end
                MODE_SCANNER: begin
                    if (i_pix.pixel_index == r_head) begin
                        dec_pass = 1'b1;
                        dec_zero = 1'b0;
                    end else if (trail_hit) begin
                        // steps minus step number: trail - (distance - 1)
                        dec_zero = 1'b0;
                        dec_m    = trail - trail_dist[3:0] + 4'd1;
                    end
                end
                MODE_GLOW: begin
                    dec_zero = 1'b0;
                    dec_glow = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // serial step logic
    // ------------------------------------------------------------------
    logic [4:0] mod_sh;
    logic [3:0] mod_next;
    logic [4:0] div_sh [NUM_CH];
    logic       div_ge [NUM_CH];
    logic       out_free;

    always_comb begin
        mod_sh   = {r_mod_rem, r_x[IDX_W-1]};
        mod_next = (mod_sh >= {1'b0, r_w}) ? 4'(mod_sh - {1'b0, r_w}) : mod_sh[3:0];
        for (int j = 0; j < NUM_CH; j++) begin
            div_sh[j] = {r_rem[j], r_dvd[j][6]};
            div_ge[j] = div_sh[j] >= {1'b0, r_div_m};
        end
    end

    assign out_free = !r_out_valid || o_pix.ready;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_pix.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_pix.ready = 1'b1;
                if (i_pix.valid) begin
                    if (dec_glow) begin
                        n_state = ST_MOD;
                    end else if (dec_zero || dec_pass) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_MOD: begin
                if (r_cnt == 3'(MOD_STEPS - 1)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == 3'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= '0;
        end else if ((r_state == ST_MOD) && (r_cnt == 3'(MOD_STEPS - 1))) begin
            r_cnt <= '0;
        end else if ((r_state == ST_MOD) || (r_state == ST_DIV)) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    // datapath: load on accept, then modulo and division steps
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x       <= i_pix.pixel_index;
            r_mod_rem <= 4'd0;
            r_w       <= glow_w;
            r_div_m   <= dec_m;
            r_pass    <= dec_pass || dec_zero;
            r_last    <= i_pix.frame_last;
            for (int j = 0; j < NUM_CH; j++) begin
                r_chan[j] <= dec_zero ? 8'd0 : colour_ch[j];
                r_dvd[j]  <= colour_ch[j][7:1];
                r_rem[j]  <= 4'd0;
            end
        end else if (r_state == ST_MOD) begin
            r_x       <= {r_x[IDX_W-2:0], 1'b0};
            r_mod_rem <= mod_next;
            if (r_cnt == 3'(MOD_STEPS - 1)) begin
                // remainder is below the width, so m is at least one
                r_div_m <= r_w - mod_next;
            end
        end else if (r_state == ST_DIV) begin
            for (int j = 0; j < NUM_CH; j++) begin
                r_rem[j] <= div_ge[j] ? 4'(div_sh[j] - {1'b0, r_div_m}) : div_sh[j][3:0];
                r_dvd[j] <= {r_dvd[j][5:0], div_ge[j]};
            end
        end
    end

    // ------------------------------------------------------------------
    // animation state, moved on by the last pixel of a frame
    // ------------------------------------------------------------------
    logic [5:0] top;
    logic [3:0] glow_dir_w;
    logic       glow_dir;

    always_comb begin
        top        = 6'(strip_n - 7'd1);
        glow_dir   = r_dir ^ (glow_w inside {4'd1, [4'd8:4'd15]});
        glow_dir_w = glow_dir ? (glow_w - 4'd1) : (glow_w + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 6'd0;
            r_dir  <= 1'b0;
            r_glow <= GLOW_RESET;
        end else if (accept && i_pix.frame_last) begin
            case (r_effect_mode)
                MODE_SCANNER: begin
                    if (r_dir) begin
                        if (({1'b0, r_head} + 7'd1) > {1'b0, top}) begin
                            r_head <= top;
                            r_dir  <= 1'b0;
                        end else begin
                            r_head <= r_head + 6'd1;
                        end
                    end else begin
                        if (r_head <= 6'd1) begin
                            r_head <= 6'd0;
                            r_dir  <= 1'b1;
                        end else if ((r_head - 6'd1) > top) begin
                            // head left beyond a shortened strip comes back
                            r_head <= top;
                            r_dir  <= 1'b1;
                        end else begin
                            r_head <= r_head - 6'd1;
                        end
                    end
                end
                MODE_GLOW: begin
                    r_dir  <= glow_dir;
                    r_glow <= glow_dir_w;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic load_out;
    assign load_out = (r_state == ST_FIN) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_global_byte  <= r_apa102_type ? {GLOBAL_MARK, r_brightness_level} : 8'd0;
            r_global_valid <= r_apa102_type;
            r_frame_done   <= r_last;
            for (int j = 0; j < NUM_CH; j++) begin
                r_out_ch[j] <= r_pass ? r_chan[j] : (r_chan[j] - {1'b0, r_dvd[j]});
            end
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.global_byte  = r_global_byte;
    assign o_pix.global_valid = r_global_valid;
    assign o_pix.red_byte     = r_out_ch[0];
    assign o_pix.green_byte   = r_out_ch[1];
    assign o_pix.blue_byte    = r_out_ch[2];
    assign o_pix.frame_done   = r_frame_done;

endmodule

`default_nettype wire
